[sv/nwpr_pkg.sv]
`default_nettype none
package nwpr_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 1024;
	localparam int MAX_COL_RUNS = 32;

	localparam int SIZE_W  = 11;
	localparam int RUN_W   = 11;
	localparam int BOX_W   = 10;
	localparam int KIND_W  = 2;
	localparam int CHAN_W  = 8;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int WALK_W  = $clog2(MAX_WIDTH + 2);
	localparam int RUNS_W  = $clog2(MAX_COL_RUNS + 1);
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);

	localparam int IN_TDATA_W     = ((3 * CHAN_W + 7) / 8) * 8;
	localparam int OUT_PAYLOAD_W  = 2 * RUN_W + 4 * BOX_W + 2;
	localparam int OUT_TDATA_W    = ((OUT_PAYLOAD_W + 7) / 8) * 8;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);
	localparam logic [CHAN_W-1:0] WHITE_LEVEL = CHAN_W'(255);

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [KIND_W-1:0] KIND_ROW = 2'd0;
	localparam logic [KIND_W-1:0] KIND_COL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BOX = 2'd2;

	typedef enum logic {
		F_RUN,
		F_WAIT
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_WALK,
		B_BOX
	} back_state_t;

	typedef struct packed {
		logic             is_frame;
		logic             rr_valid;
		logic [RUN_W-1:0] rr_start;
		logic [RUN_W-1:0] rr_end;
		logic [BOX_W-1:0] box_left;
		logic [BOX_W-1:0] box_right;
		logic [BOX_W-1:0] box_top;
		logic [BOX_W-1:0] box_bottom;
		logic             empty;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [RUN_W-1:0]  run_start;
		logic [RUN_W-1:0]  run_end;
		logic [BOX_W-1:0]  box_left;
		logic [BOX_W-1:0]  box_right;
		logic [BOX_W-1:0]  box_top;
		logic [BOX_W-1:0]  box_bottom;
		logic              frame_empty;
		logic              runs_dropped;
		logic              last;
	} out_item_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[sv/nonwhite_projection_runs_top.sv]
`default_nettype none
// Pixels: one transfer per cycle within a frame while the command queue has room; a row run
// result is queued, then registered at the output once the back is idle and its slot free.
// Frame end: input is held off while the column map is walked and cleared, one column per
// cycle over the full map depth, unless a column run result waits for the output slot.
// Reset: config returns to 1024 x 1024; a clearing pass of the column map RAM runs first,
// during which no pixel is taken (config writes still land).
module nonwhite_projection_runs_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [nwpr_pkg::IN_TDATA_W-1:0]  s_tdata,  // pixel_red, pixel_green, pixel_blue
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// run_start, run_end, box_left, box_right, box_top, box_bottom, frame_empty, runs_dropped
	output logic [nwpr_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [nwpr_pkg::KIND_W-1:0]      m_tuser,  // kind
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [nwpr_pkg::SIZE_W-1:0]      cfg_data
);
	import nwpr_pkg::*;

	logic [SIZE_W-1:0] frame_width_q, frame_height_q;
	logic [SIZE_W-1:0] w, h;
	logic              q_push, q_full, q_pop, q_empty, done;
	cmd_t              push_cmd, pop_cmd;
	logic              set_we, clr_we, map_re, map_bit;
	logic [COL_W-1:0]  set_addr, map_addr;
	logic              ram_we;
	logic [COL_W-1:0]  ram_waddr;
	out_item_t         item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= SIZE_RESET;
			frame_height_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w = clamp_size(frame_width_q, SIZE_W'(MAX_WIDTH));
	assign h = clamp_size(frame_height_q, SIZE_W'(MAX_HEIGHT));

	nwpr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.w        (w),
		.h        (h),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_push   (q_push),
		.q_cmd    (push_cmd),
		.q_full   (q_full),
		.done     (done),
		.set_we   (set_we),
		.set_addr (set_addr)
	);

	nwpr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	// front sets bits only while the back is idle; the walk clears behind its reads
	assign ram_we    = set_we || clr_we;
	assign ram_waddr = clr_we ? map_addr : set_addr;

	nwpr_ram #(
		.WIDTH (1),
		.DEPTH (MAX_WIDTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (!clr_we),
		.re    (map_re),
		.raddr (map_addr),
		.rdata (map_bit)
	);

	nwpr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.w        (w),
		.q_cmd    (pop_cmd),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.done     (done),
		.map_re   (map_re),
		.map_addr (map_addr),
		.clr_we   (clr_we),
		.map_bit  (map_bit),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_item   (item)
	);

	assign m_tdata = OUT_TDATA_W'({item.runs_dropped, item.frame_empty, item.box_bottom,
		item.box_top, item.box_right, item.box_left, item.run_end, item.run_start});
	assign m_tuser = item.kind;
	assign m_tlast = item.last;

endmodule
`default_nettype wire

[sv/nwpr_ram.sv]
`default_nettype none
module nwpr_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[sv/nwpr_queue.sv]
`default_nettype none
module nwpr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nwpr_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output nwpr_pkg::cmd_t pop_cmd,
	output logic           empty
);
	import nwpr_pkg::*;

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full    = count_q == (QPTR_W+1)'(QDEPTH);
	assign empty   = count_q == '0;
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue pop while empty");

endmodule
`default_nettype wire

[sv/nwpr_front.sv]
`default_nettype none
module nwpr_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [nwpr_pkg::SIZE_W-1:0]     w,
	input  logic [nwpr_pkg::SIZE_W-1:0]     h,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [nwpr_pkg::IN_TDATA_W-1:0] s_tdata,
	output logic                            q_push,
	output nwpr_pkg::cmd_t                  q_cmd,
	input  logic                            q_full,
	input  logic                            done,
	output logic                            set_we,
	output logic [nwpr_pkg::COL_W-1:0]      set_addr
);
	import nwpr_pkg::*;

	front_state_t     state_q, state_d;
	logic [COL_W-1:0] col_q, col_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic             rhi_q, rhi_d;
	logic             in_run_q, in_run_d;
	logic [RUN_W-1:0] begin_q, begin_d;
	logic [COL_W-1:0] minc_q, minc_d, maxc_q, maxc_d;
	logic [ROW_W-1:0] minr_q, minr_d, maxr_q, maxr_d;
	logic             any_q, any_d;

	logic [CHAN_W-1:0] red, green, blue;
	logic              acc, ink, row_end, frame_end, rhi_now, closing;

	assign red   = s_tdata[CHAN_W-1:0];
	assign green = s_tdata[2*CHAN_W-1:CHAN_W];
	assign blue  = s_tdata[3*CHAN_W-1:2*CHAN_W];
	assign ink   = (red != WHITE_LEVEL) || (green != WHITE_LEVEL) || (blue != WHITE_LEVEL);

	assign s_tready  = (state_q == F_RUN) && !q_full;
	assign acc       = s_tvalid && s_tready;
	assign row_end   = SIZE_W'(col_q) >= (w - SIZE_W'(1));
	assign frame_end = row_end && (SIZE_W'(row_q) >= (h - SIZE_W'(1)));
	assign rhi_now   = rhi_q || ink;
	assign set_addr  = col_q;

	always_comb begin
		state_d  = state_q;
		col_d    = col_q;
		row_d    = row_q;
		rhi_d    = rhi_q;
		in_run_d = in_run_q;
		begin_d  = begin_q;
		minc_d   = minc_q;
		maxc_d   = maxc_q;
		minr_d   = minr_q;
		maxr_d   = maxr_q;
		any_d    = any_q;
		q_push   = 1'b0;
		q_cmd    = '0;
		set_we   = 1'b0;
		closing  = 1'b0;
		case (state_q)
			F_WAIT: begin
				if (done) begin
					state_d = F_RUN;
				end
			end
			F_RUN: begin
				if (acc) begin
					if (ink) begin
						set_we = 1'b1;
						rhi_d  = 1'b1;
						any_d  = 1'b1;
						if (!any_q) begin
							minc_d = col_q;
							maxc_d = col_q;
							minr_d = row_q;
							maxr_d = row_q;
						end else begin
							if (col_q < minc_q) minc_d = col_q;
							if (col_q > maxc_q) maxc_d = col_q;
							if (row_q < minr_q) minr_d = row_q;
							if (row_q > maxr_q) maxr_d = row_q;
						end
					end
					if (!row_end) begin
						col_d = col_q + COL_W'(1);
					end else begin
						if (rhi_now && !in_run_q) begin
							in_run_d = 1'b1;
							begin_d  = RUN_W'(row_q);
						end else if (!rhi_now && in_run_q) begin
							in_run_d = 1'b0;
							closing  = 1'b1;
						end
						rhi_d = 1'b0;
						col_d = '0;
						if (!frame_end) begin
							row_d = row_q + ROW_W'(1);
							if (closing) begin
								q_push         = 1'b1;
								q_cmd.rr_valid = 1'b1;
								q_cmd.rr_start = begin_q;
								q_cmd.rr_end   = RUN_W'(row_q);
							end
						end else begin
							q_push         = 1'b1;
							q_cmd.is_frame = 1'b1;
							q_cmd.rr_valid = closing || in_run_d;
							q_cmd.rr_start = begin_d;
							q_cmd.rr_end   = closing ? RUN_W'(row_q) : RUN_W'(h);
							q_cmd.empty    = !any_d;
							if (any_d) begin
								q_cmd.box_left   = BOX_W'(minc_d);
								q_cmd.box_right  = BOX_W'(maxc_d);
								q_cmd.box_top    = BOX_W'(minr_d);
								q_cmd.box_bottom = BOX_W'(maxr_d);
							end
							row_d    = '0;
							in_run_d = 1'b0;
							begin_d  = '0;
							minc_d   = '1;
							maxc_d   = '0;
							minr_d   = '1;
							maxr_d   = '0;
							any_d    = 1'b0;
							state_d  = F_WAIT;
						end
					end
				end
			end
			default: state_d = F_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_WAIT;
			col_q    <= '0;
			row_q    <= '0;
			rhi_q    <= 1'b0;
			in_run_q <= 1'b0;
			begin_q  <= '0;
			minc_q   <= '1;
			maxc_q   <= '0;
			minr_q   <= '1;
			maxr_q   <= '0;
			any_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			col_q    <= col_d;
			row_q    <= row_d;
			rhi_q    <= rhi_d;
			in_run_q <= in_run_d;
			begin_q  <= begin_d;
			minc_q   <= minc_d;
			maxc_q   <= maxc_d;
			minr_q   <= minr_d;
			maxr_q   <= maxr_d;
			any_q    <= any_d;
		end
	end

endmodule
`default_nettype wire

[sv/nwpr_back.sv]
`default_nettype none
module nwpr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [nwpr_pkg::SIZE_W-1:0] w,
	input  nwpr_pkg::cmd_t              q_cmd,
	input  logic                        q_empty,
	output logic                        q_pop,
	output logic                        done,
	output logic                        map_re,
	output logic [nwpr_pkg::COL_W-1:0]  map_addr,
	output logic                        clr_we,
	input  logic                        map_bit,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output nwpr_pkg::out_item_t         m_item
);
	import nwpr_pkg::*;

	back_state_t       state_q, state_d;
	logic              sweep_q, sweep_d;
	logic [WALK_W-1:0] a_q, a_d;
	logic              v_s1, v_d;
	logic [WALK_W-1:0] idx_s1, idx_d;
	logic              open_q, open_d;
	logic [WALK_W-1:0] start_q, start_d;
	logic [RUNS_W-1:0] runs_q, runs_d;
	logic              dropped_q, dropped_d;
	cmd_t              cmd_q, cmd_d;
	logic              out_valid_q;
	out_item_t         out_q, out_d;

	logic slot_free, out_load, on, closing, emit, adv;

	assign slot_free = !out_valid_q || m_tready;
	assign map_addr  = a_q[COL_W-1:0];
	assign on        = v_s1 && (idx_s1 < WALK_W'(w)) && map_bit;
	assign closing   = v_s1 && !on && open_q;
	assign emit      = closing && (runs_q < RUNS_W'(MAX_COL_RUNS)) && !sweep_q;

	always_comb begin
		state_d   = state_q;
		sweep_d   = sweep_q;
		a_d       = a_q;
		v_d       = v_s1;
		idx_d     = idx_s1;
		open_d    = open_q;
		start_d   = start_q;
		runs_d    = runs_q;
		dropped_d = dropped_q;
		cmd_d     = cmd_q;
		out_load  = 1'b0;
		out_d     = '0;
		q_pop     = 1'b0;
		done      = 1'b0;
		map_re    = 1'b0;
		clr_we    = 1'b0;
		adv       = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!q_empty && slot_free) begin
					q_pop           = 1'b1;
					out_d.kind      = KIND_ROW;
					out_d.run_start = q_cmd.rr_start;
					out_d.run_end   = q_cmd.rr_end;
					if (!q_cmd.is_frame) begin
						out_load   = 1'b1;
						out_d.last = 1'b1;
					end else begin
						out_load  = q_cmd.rr_valid;
						cmd_d     = q_cmd;
						state_d   = B_WALK;
						a_d       = '0;
						v_d       = 1'b0;
						open_d    = 1'b0;
						runs_d    = '0;
						dropped_d = 1'b0;
					end
				end
			end
			B_WALK: begin
				adv = !emit || slot_free;
				if (adv) begin
					if (a_q <= WALK_W'(MAX_WIDTH)) begin
						v_d   = 1'b1;
						idx_d = a_q;
						a_d   = a_q + WALK_W'(1);
						if (a_q < WALK_W'(MAX_WIDTH)) begin
							map_re = 1'b1;
							clr_we = 1'b1;
						end
					end else begin
						v_d = 1'b0;
					end
					if (v_s1) begin
						if (on && !open_q) begin
							open_d  = 1'b1;
							start_d = idx_s1;
						end else if (closing) begin
							open_d = 1'b0;
							if (runs_q < RUNS_W'(MAX_COL_RUNS)) begin
								runs_d = runs_q + RUNS_W'(1);
							end else begin
								dropped_d = 1'b1;
							end
							out_load        = emit;
							out_d.kind      = KIND_COL;
							out_d.run_start = RUN_W'(start_q);
							out_d.run_end   = RUN_W'(idx_s1);
						end
						if (idx_s1 == WALK_W'(MAX_WIDTH)) begin
							if (sweep_q) begin
								sweep_d = 1'b0;
								done    = 1'b1;
								state_d = B_IDLE;
							end else begin
								state_d = B_BOX;
							end
						end
					end
				end
			end
			B_BOX: begin
				if (slot_free) begin
					out_load           = 1'b1;
					out_d.kind         = KIND_BOX;
					out_d.box_left     = cmd_q.box_left;
					out_d.box_right    = cmd_q.box_right;
					out_d.box_top      = cmd_q.box_top;
					out_d.box_bottom   = cmd_q.box_bottom;
					out_d.frame_empty  = cmd_q.empty;
					out_d.runs_dropped = dropped_q;
					out_d.last         = 1'b1;
					done               = 1'b1;
					state_d            = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_WALK;
			sweep_q     <= 1'b1;
			a_q         <= '0;
			v_s1        <= 1'b0;
			idx_s1      <= '0;
			open_q      <= 1'b0;
			start_q     <= '0;
			runs_q      <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			sweep_q   <= sweep_d;
			a_q       <= a_d;
			v_s1      <= v_d;
			idx_s1    <= idx_d;
			open_q    <= open_d;
			start_q   <= start_d;
			runs_q    <= runs_d;
			dropped_q <= dropped_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_item   = out_q;

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_WALK) |-> (a_q <= WALK_W'(MAX_WIDTH + 1)))
		else $error("column walk ran past the map");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> slot_free) else $error("result overwritten before transfer");
	a_runs_cap: assert property (@(posedge clk) disable iff (!arst_n)
		runs_q <= RUNS_W'(MAX_COL_RUNS)) else $error("column run count over limit");

endmodule
`default_nettype wire
